// File: hdl/llss_pkg.sv
// Package for the least-loaded server selector.
// Holds field widths, default sizes, codes and the count-pair type.
// No dependencies; all other files of the block use it.
package llss_pkg;

  localparam int CountW        = 32;
  localparam int IdxW          = 5;
  localparam int RegCountW     = 6;
  localparam int ApbDataW      = 32;
  localparam int ApbAddrW      = 3;
  localparam int DefMaxServers = 32;

  // Register word index inside the configuration space.
  localparam logic [0:0] RegServerCount = 1'b0;

  typedef enum logic [0:0] {
    OpDispatch = 1'b0,
    OpHealth   = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    KindDispatch = 1'b0,
    KindHealth   = 1'b1
  } kind_e;

  // One store entry: the request and error counts of a server.
  typedef struct packed {
    logic [CountW-1:0] req;
    logic [CountW-1:0] err;
  } cnt_pair_t;

endpackage

// File: hdl/llss_req_if.sv
// Request channel of the least-loaded server selector: valid/ready plus payload.
// Depends on llss_pkg for widths and the opcode type.
interface llss_req_if;
  logic                          valid;
  logic                          ready;
  llss_pkg::op_e                 opcode;
  logic [llss_pkg::IdxW-1:0]     target_idx;
  logic [llss_pkg::CountW-1:0]   error_value;
  logic [llss_pkg::CountW-1:0]   request_value;

  modport source (output valid, opcode, target_idx, error_value, request_value,
                  input ready);
  modport sink (input valid, opcode, target_idx, error_value, request_value,
                output ready);
endinterface

// File: hdl/llss_rsp_if.sv
// Result channel of the least-loaded server selector: valid/ready plus payload.
// Depends on llss_pkg for widths and the result kind type.
interface llss_rsp_if;
  logic                      valid;
  logic                      ready;
  llss_pkg::kind_e           result_kind;
  logic [llss_pkg::IdxW-1:0] chosen_server;

  modport source (output valid, result_kind, chosen_server, input ready);
  modport sink (input valid, result_kind, chosen_server, output ready);
endinterface

// File: hdl/llss_store.sv
// Count store: one synchronous memory of request/error pairs, one read and one write port.
// Per-entry valid bits make entries that were never written read as zero after reset.
// Depends on llss_pkg for the entry type.
module llss_store #(
  parameter int Depth = llss_pkg::DefMaxServers,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output llss_pkg::cnt_pair_t rd_data_o,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  llss_pkg::cnt_pair_t wr_data_i
);

  llss_pkg::cnt_pair_t mem [Depth];
  logic [Depth-1:0]    vld_q;
  llss_pkg::cnt_pair_t rd_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// File: hdl/least_loaded_server_selector.sv
// Top level of the least-loaded server selector: sequencer, APB register and result register.
// Depends on llss_pkg, llss_req_if, llss_rsp_if and llss_store.
//
//   Channel   Dir  Protocol         Payload
//   req_i     in   valid/ready      opcode, target_idx, error_value, request_value
//   rsp_o     out  valid/ready      result_kind, chosen_server
//   APB       in   psel/penable     server_count at byte address 0
//
// A dispatch reads N entries, N being the number of servers scanned (server_count
// clamped to 1..MAX_SERVERS, fewer when an idle server ends the scan early).
// The store reads one entry per cycle from a registered read port; that read port sets
// the rate. After reset every count reads as zero at once. A result waiting in the
// output register blocks the next result and, since the sequencer holds in StDone
// until the register is free, also the next transfer on req_i.
module least_loaded_server_selector #(
  parameter int MAX_SERVERS = llss_pkg::DefMaxServers
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  llss_req_if.sink                        req_i,
  llss_rsp_if.source                      rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [llss_pkg::ApbAddrW-1:0]   paddr,
  input  logic [llss_pkg::ApbDataW-1:0]   pwdata,
  output logic [llss_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);

  localparam int AW = $clog2(MAX_SERVERS);
  localparam int CW = $clog2(MAX_SERVERS + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  state_e                              state_q;
  logic [llss_pkg::RegCountW-1:0]      cfg_count_q;
  logic [CW-1:0]                       limit_c, limit_q, nxt_q;
  logic [AW-1:0]                       cur_q, best_idx_q;
  llss_pkg::cnt_pair_t                 best_q;
  llss_pkg::kind_e                     kind_q;
  logic [llss_pkg::IdxW-1:0]           res_idx_q;
  logic                                out_valid_q;
  llss_pkg::kind_e                     out_kind_q;
  logic [llss_pkg::IdxW-1:0]           out_idx_q;

  logic                                rd_en, wr_en;
  logic [AW-1:0]                       rd_addr, wr_addr;
  llss_pkg::cnt_pair_t                 rd_data, wr_data;
  logic                                in_xfer, slot_free, take, stop, idx_in_store;
  logic [llss_pkg::CountW-1:0]         req_inc;

  // APB register: word 0 holds server_count, anything above reads as zero.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == llss_pkg::RegServerCount)
                  ? llss_pkg::ApbDataW'(cfg_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q <= llss_pkg::RegCountW'(1);
    end else if (psel && penable && pwrite && (paddr[2] == llss_pkg::RegServerCount)) begin
      cfg_count_q <= pwdata[llss_pkg::RegCountW-1:0];
    end
  end

  // A count of zero scans only server 0; a count above the store size is clamped.
  always_comb begin
    if (cfg_count_q == '0) begin
      limit_c = CW'(1);
    end else if (32'(cfg_count_q) > 32'(MAX_SERVERS)) begin
      limit_c = CW'(MAX_SERVERS);
    end else begin
      limit_c = CW'(cfg_count_q);
    end
  end

  assign req_i.ready  = (state_q == StIdle);
  assign in_xfer      = req_i.valid && req_i.ready;
  assign slot_free    = !out_valid_q || rsp_o.ready;
  assign idx_in_store = 32'(req_i.target_idx) < 32'(MAX_SERVERS);

  // Scan step on the entry read in the previous cycle. Server 0 is only the
  // starting candidate; any later idle server ends the scan.
  always_comb begin
    take = (cur_q == '0) || (rd_data.req == '0) || (rd_data.req < best_q.req) ||
           ((rd_data.req == best_q.req) && (rd_data.err < best_q.err));
    stop = ((cur_q != '0) && (rd_data.req == '0)) || ((CW'(cur_q) + CW'(1)) == limit_q);
  end

  assign req_inc = (best_q.req == '1) ? best_q.req : best_q.req + llss_pkg::CountW'(1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = best_idx_q;
    wr_data = '{req: req_inc, err: best_q.err};
    case (state_q)
      StIdle: begin
        if (in_xfer && (req_i.opcode == llss_pkg::OpDispatch)) begin
          rd_en = 1'b1;
        end
        if (in_xfer && (req_i.opcode == llss_pkg::OpHealth)) begin
          wr_en   = idx_in_store;
          wr_addr = AW'(req_i.target_idx);
          wr_data = '{req: req_i.request_value, err: req_i.error_value};
        end
      end
      StScan: begin
        if (!stop) begin
          rd_en   = 1'b1;
          rd_addr = nxt_q[AW-1:0];
        end
      end
      StDone: begin
        wr_en = slot_free && (kind_q == llss_pkg::KindDispatch);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  llss_store #(
    .Depth(MAX_SERVERS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      kind_q      <= llss_pkg::KindDispatch;
      out_kind_q  <= llss_pkg::KindDispatch;
      limit_q     <= CW'(1);
      nxt_q       <= '0;
      cur_q       <= '0;
      best_idx_q  <= '0;
      res_idx_q   <= '0;
      out_idx_q   <= '0;
      best_q      <= '0;
    end else begin
      // A new result loaded in the same cycle keeps the register full.
      if (out_valid_q && rsp_o.ready && !((state_q == StDone) && slot_free)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_xfer) begin
            if (req_i.opcode == llss_pkg::OpDispatch) begin
              kind_q  <= llss_pkg::KindDispatch;
              limit_q <= limit_c;
              cur_q   <= '0;
              nxt_q   <= CW'(1);
              state_q <= StScan;
            end else begin
              kind_q    <= llss_pkg::KindHealth;
              res_idx_q <= req_i.target_idx;
              state_q   <= StDone;
            end
          end
        end
        StScan: begin
          if (take) begin
            best_q     <= rd_data;
            best_idx_q <= cur_q;
            res_idx_q  <= llss_pkg::IdxW'(cur_q);
          end
          if (stop) begin
            state_q <= StDone;
          end else begin
            cur_q <= nxt_q[AW-1:0];
            nxt_q <= nxt_q + CW'(1);
          end
        end
        StDone: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= kind_q;
            out_idx_q   <= res_idx_q;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.result_kind   = out_kind_q;
  assign rsp_o.chosen_server = out_idx_q;

endmodule

// File: tb/sv/least_loaded_server_selector_test.sv
// Self-checking testbench for least_loaded_server_selector: predicts each chosen server
// and health acknowledge, and compares every result transfer against that prediction.
// Depends on llss_pkg, llss_req_if, llss_rsp_if and the selector RTL.
module least_loaded_server_selector_test;

  typedef struct packed {
    llss_pkg::kind_e           kind;
    logic [llss_pkg::IdxW-1:0] server;
  } choice_t;

  // Mirror of the server count store, plus the queue of predicted results.
  class choice_board;
    logic [llss_pkg::RegCountW-1:0] server_count;
    logic [llss_pkg::CountW-1:0]    req_cnt [llss_pkg::DefMaxServers];
    logic [llss_pkg::CountW-1:0]    err_cnt [llss_pkg::DefMaxServers];
    choice_t                        expected_choices [$];
    int                             mismatches;

    function new();
      server_count = llss_pkg::RegCountW'(1);
      foreach (req_cnt[i]) begin
        req_cnt[i] = '0;
        err_cnt[i] = '0;
      end
      mismatches = 0;
    endfunction

    // Server 0 is only the starting candidate. Any later idle server ends the scan;
    // otherwise fewer requests win and equal requests go to fewer errors.
    function logic [llss_pkg::IdxW-1:0] least_loaded();
      int limit;
      int best;
      int i;
      bit found;
      limit = (server_count > llss_pkg::DefMaxServers) ? llss_pkg::DefMaxServers
                                                        : int'(server_count);
      best  = 0;
      found = 1'b0;
      for (i = 1; i < limit; i++) begin
        if (!found) begin
          if (req_cnt[i] == '0) begin
            best  = i;
            found = 1'b1;
          end else if (req_cnt[i] < req_cnt[best]) begin
            best = i;
          end else if (req_cnt[i] == req_cnt[best] && err_cnt[i] < err_cnt[best]) begin
            best = i;
          end
        end
      end
      return best[llss_pkg::IdxW-1:0];
    endfunction

    function void note_request(llss_pkg::op_e op, logic [llss_pkg::IdxW-1:0] idx,
                               logic [llss_pkg::CountW-1:0] errv,
                               logic [llss_pkg::CountW-1:0] reqv);
      choice_t c;
      if (op == llss_pkg::OpDispatch) begin
        c.kind   = llss_pkg::KindDispatch;
        c.server = least_loaded();
        if (req_cnt[c.server] != '1) req_cnt[c.server] += llss_pkg::CountW'(1);
      end else begin
        c.kind   = llss_pkg::KindHealth;
        c.server = idx;
        if (int'(idx) < llss_pkg::DefMaxServers) begin
          err_cnt[idx] = errv;
          req_cnt[idx] = reqv;
        end
      end
      expected_choices.push_back(c);
    endfunction

    function void check_choice(llss_pkg::kind_e kind, logic [llss_pkg::IdxW-1:0] server);
      choice_t c;
      if (expected_choices.size() == 0) begin
        $error("unexpected result: result_kind %0d chosen_server %0d", kind, server);
        mismatches++;
        return;
      end
      c = expected_choices.pop_front();
      if (kind !== c.kind) begin
        $error("result_kind: expected %0d, actual %0d", c.kind, kind);
        mismatches++;
      end
      if (server !== c.server) begin
        $error("chosen_server: expected %0d, actual %0d", c.server, server);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [llss_pkg::ApbAddrW-1:0] paddr;
  logic [llss_pkg::ApbDataW-1:0] pwdata;
  logic [llss_pkg::ApbDataW-1:0] prdata;
  logic                          pready;
  bit                            idle_on;
  choice_board                   tracker;

  llss_req_if req_ch ();
  llss_rsp_if rsp_ch ();

  least_loaded_server_selector DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // Result side back-pressure in random bursts.
  initial begin
    int burst;
    burst = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (burst == 0 && idle_on && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 7);
      if (burst > 0) begin
        rsp_ch.ready <= 1'b0;
        burst--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      tracker.check_choice(rsp_ch.result_kind, rsp_ch.chosen_server);
  end

  // Holds valid until the transfer; leaves valid high for a following item.
  task automatic send_item(llss_pkg::op_e op, logic [llss_pkg::IdxW-1:0] idx,
                           logic [llss_pkg::CountW-1:0] errv,
                           logic [llss_pkg::CountW-1:0] reqv);
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.target_idx    <= idx;
    req_ch.error_value   <= errv;
    req_ch.request_value <= reqv;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    tracker.note_request(op, idx, errv, reqv);
  endtask

  task automatic dispatch();
    logic [llss_pkg::IdxW-1:0] idx;
    idx = llss_pkg::IdxW'($urandom_range(0, 31));
    send_item(llss_pkg::OpDispatch, idx, $urandom, $urandom);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (tracker.expected_choices.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_server_count(logic [llss_pkg::RegCountW-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {llss_pkg::RegServerCount, 2'b00};
    pwdata  <= {{(llss_pkg::ApbDataW - llss_pkg::RegCountW){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.server_count = value;
  endtask

  // Mostly small counts so that ties and idle servers are common.
  function automatic logic [llss_pkg::CountW-1:0] pick_count(int small_max);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(0, small_max);
    else if (sel < 8) return 32'hFFFF_FFFF - $urandom_range(0, 2);
    else return $urandom;
  endfunction

  task automatic random_item();
    int span;
    logic [llss_pkg::IdxW-1:0] idx;
    span = (tracker.server_count == 0) ? 1 :
           (tracker.server_count > llss_pkg::DefMaxServers) ? llss_pkg::DefMaxServers :
           int'(tracker.server_count);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    if ($urandom_range(0, 99) < 55) begin
      dispatch();
    end else begin
      idx = ($urandom_range(0, 4) == 0) ? llss_pkg::IdxW'($urandom_range(0, 31))
                                        : llss_pkg::IdxW'($urandom_range(0, span - 1));
      send_item(llss_pkg::OpHealth, idx, pick_count(3), pick_count(4));
    end
  endtask

  initial begin
    int phase;
    int n;
    logic [llss_pkg::RegCountW-1:0] setting;
    tracker = new();
    idle_on = 1'b1;
    rst_ni               <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.opcode        <= llss_pkg::OpDispatch;
    req_ch.target_idx    <= '0;
    req_ch.error_value   <= '0;
    req_ch.request_value <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dispatch();
    write_server_count(6'd0);
    dispatch();
    write_server_count(6'd2);
    send_item(llss_pkg::OpHealth, 5'd0, 32'd0, 32'd0);
    // Both servers idle: server 1 wins, server 0 is only the starting candidate.
    dispatch();
    send_item(llss_pkg::OpHealth, 5'd0, '1, '1);
    send_item(llss_pkg::OpHealth, 5'd1, 32'd0, '1);
    // Equal full request counts: fewer errors wins and the count stays saturated.
    dispatch();
    dispatch();
    send_item(llss_pkg::OpHealth, 5'd0, 32'd5, 32'd1);
    send_item(llss_pkg::OpHealth, 5'd1, 32'd0, 32'h8000_0000);
    dispatch();
    // Written although it lies beyond the servers in use.
    send_item(llss_pkg::OpHealth, 5'd31, 32'hAAAA_AAAA, 32'h5555_5555);
    write_server_count(6'd63);
    dispatch();
    send_item(llss_pkg::OpHealth, 5'd2, 32'h5555_5555, 32'hAAAA_AAAA);
    dispatch();
    dispatch();

    for (phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0:       setting = llss_pkg::RegCountW'($urandom_range(2, 6));
        1:       setting = llss_pkg::RegCountW'($urandom_range(0, 63));
        2:       setting = (phase % 8 == 2) ? 6'd32 : 6'd63;
        default: setting = llss_pkg::RegCountW'($urandom_range(7, 31));
      endcase
      write_server_count(setting);
      idle_on = (phase == 11) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (n = 0; n < 80; n++) random_item();
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_choices.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
